/* hw/rtl/ietk_pkg.sv */
// ----------------------------------------------------------------------------
// ietk_pkg
// Shared types and codes for the input event click tracker.
// ----------------------------------------------------------------------------
package ietk_pkg;

	typedef logic [2:0] action_t;
	typedef logic [7:0] key_code_t;
	typedef logic [2:0] button_t;
	typedef logic signed [15:0] coord_t;
	typedef logic [1:0] click_count_t;
	typedef logic [4:0] flags_t;
	typedef logic [15:0] timeout_t;

	// event codes
	localparam action_t ACT_KEY_DOWN = 3'd0;
	localparam action_t ACT_KEY_UP   = 3'd1;
	localparam action_t ACT_BTN_DOWN = 3'd2;
	localparam action_t ACT_BTN_UP   = 3'd3;
	localparam action_t ACT_WHEEL    = 3'd4;
	localparam action_t ACT_MOVE     = 3'd5;
	localparam action_t ACT_FRAME    = 3'd6;
	localparam action_t ACT_TICK     = 3'd7;

	localparam int BUTTON_SLOTS = 6;
	localparam int FLAG_BITS = 5;
	localparam button_t BTN_NONE = 3'd0;
	localparam button_t BTN_LAST = 3'd5;
	localparam click_count_t COUNT_LIMIT = 2'd3;
	localparam click_count_t COUNT_FIRST = 2'd1;
	localparam click_count_t COUNT_SECOND = 2'd2;
	localparam key_code_t KEY_NONE = 8'd0;
	localparam timeout_t TIMEOUT_RESET = 16'd300;

	// key map request, one per accepted transaction
	typedef struct packed {
		logic      en;
		action_t   action;
		key_code_t key_code;
	} key_req_t;

endpackage

/* hw/rtl/ietk_if.sv */
// ----------------------------------------------------------------------------
// ietk_if
// Valid/ready channels for input events and tracker results.
// ----------------------------------------------------------------------------
interface ietk_evt_if;
	import ietk_pkg::*;

	logic      valid;
	logic      ready;
	action_t   action;
	key_code_t key_code;
	button_t   button;
	coord_t    wheel_delta;
	coord_t    pointer_x_in;
	coord_t    pointer_y_in;

	modport source (
		output valid, action, key_code, button, wheel_delta, pointer_x_in, pointer_y_in,
		input  ready
	);
	modport sink (
		input  valid, action, key_code, button, wheel_delta, pointer_x_in, pointer_y_in,
		output ready
	);
endinterface

interface ietk_res_if;
	import ietk_pkg::*;

	logic      valid;
	logic      ready;
	logic      key_state;
	flags_t    single_click_flags;
	flags_t    double_click_flags;
	logic      wheel_plus;
	logic      wheel_minus;
	coord_t    pointer_x;
	coord_t    pointer_y;
	key_code_t first_key;
	button_t   first_button;

	modport source (
		output valid, key_state, single_click_flags, double_click_flags, wheel_plus,
		       wheel_minus, pointer_x, pointer_y, first_key, first_button,
		input  ready
	);
	modport sink (
		input  valid, key_state, single_click_flags, double_click_flags, wheel_plus,
		       wheel_minus, pointer_x, pointer_y, first_key, first_button,
		output ready
	);
endinterface

/* hw/rtl/ietk_key_map.sv */
// ----------------------------------------------------------------------------
// ietk_key_map
// Pressed bit per key in a one-bit-wide memory, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module ietk_key_map #(
	parameter int KEY_COUNT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ietk_pkg::key_req_t req,
	output logic              key_bit,
	output logic              ready
);
	import ietk_pkg::*;

	localparam int KEY_AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int EXT_W  = (KEY_AW > 8) ? KEY_AW : 8;

	logic              mem [KEY_COUNT];
	logic [KEY_AW-1:0] clr_idx_q;
	logic              clearing_q;
	logic [EXT_W-1:0]  key_ext;
	logic [KEY_AW-1:0] addr;
	logic              key_ok;
	logic              wr_en;
	logic [KEY_AW-1:0] wr_addr;
	logic              wr_data;

	assign key_ext = EXT_W'(req.key_code);
	assign addr    = key_ext[KEY_AW-1:0];
	assign key_ok  = 32'(req.key_code) < 32'(KEY_COUNT);
	assign ready   = !clearing_q;

	always_comb begin
		if (clearing_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			wr_data = 1'b0;
		end else begin
			wr_en   = req.en && key_ok &&
			          (req.action == ACT_KEY_DOWN || req.action == ACT_KEY_UP);
			wr_addr = addr;
			wr_data = (req.action == ACT_KEY_DOWN);
		end
	end

	// clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == KEY_AW'(KEY_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// read returns the value before this edge's write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.en && key_ok) begin
			key_bit <= mem[addr];
		end
	end

endmodule

/* hw/rtl/input_event_click_tracker_top.sv */
// ----------------------------------------------------------------------------
// input_event_click_tracker_top
// Keyboard and mouse event tracker with per-button multi-click detection.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake        payload
//  evt      in         valid / ready    action, key_code, button, wheel_delta,
//                                       pointer_x_in, pointer_y_in
//  res      out        valid / ready    key_state, click flags, wheel signs,
//                                       pointer, first key, first button
//  cfg      in         cfg_we           cfg_wdata = click_timeout_ticks
//
//  one transaction a cycle sustained while res.ready is high; the input register takes the event at
//  its accepting edge and the result register is loaded from it as it advances
//  after reset the key memory is cleared one entry a cycle with evt.ready low,
//  configuration writes still taken
//  a stalled result holds the result register; the input register keeps
//  accepting until it is full as well
//
module input_event_click_tracker_top #(
	parameter int KEY_COUNT  = 256,
	parameter int TIMER_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  ietk_pkg::timeout_t  cfg_wdata,
	ietk_evt_if.sink            evt,
	ietk_res_if.source          res
);
	import ietk_pkg::*;

	typedef logic [TIMER_BITS-1:0] timer_t;

	// configuration
	timeout_t     timeout_q;

	// input register
	logic         valid_s1;
	action_t      action_s1;
	key_code_t    key_code_s1;
	button_t      button_s1;
	coord_t       wheel_delta_s1;
	coord_t       pointer_x_in_s1;
	coord_t       pointer_y_in_s1;

	// tracker state
	logic         pressed_q [BUTTON_SLOTS];
	click_count_t count_q   [BUTTON_SLOTS];
	timer_t       since_q   [BUTTON_SLOTS];
	coord_t       wheel_q;
	coord_t       pointer_x_q;
	coord_t       pointer_y_q;
	key_code_t    first_key_q;
	button_t      first_button_q;

	// next state
	logic         pressed_nxt [BUTTON_SLOTS];
	click_count_t count_nxt   [BUTTON_SLOTS];
	timer_t       since_nxt   [BUTTON_SLOTS];
	coord_t       wheel_nxt;
	coord_t       pointer_x_nxt;
	coord_t       pointer_y_nxt;
	key_code_t    first_key_nxt;
	button_t      first_button_nxt;
	flags_t       single_nxt;
	flags_t       double_nxt;
	logic         key_state_nxt;

	// result register
	logic         res_valid_q;
	logic         key_state_q;
	flags_t       single_q;
	flags_t       double_q;
	logic         wheel_plus_q;
	logic         wheel_minus_q;
	coord_t       res_pointer_x_q;
	coord_t       res_pointer_y_q;
	key_code_t    res_first_key_q;
	button_t      res_first_button_q;

	logic         evt_fire;
	logic         s1_adv;
	logic         key_ok_s1;
	logic         btn_ok_s1;
	logic         key_bit;
	logic         map_ready;
	logic         held_zero_count;
	key_req_t     key_req;

	// handshake: result register drains, input register refills in the same cycle
	assign s1_adv    = valid_s1 && (!res_valid_q || res.ready);
	assign evt.ready = map_ready && (!valid_s1 || s1_adv);
	assign evt_fire  = evt.valid && evt.ready;

	// key map is read and written as the transaction is taken
	assign key_req.en       = evt_fire;
	assign key_req.action   = evt.action;
	assign key_req.key_code = evt.key_code;

	ietk_key_map #(
		.KEY_COUNT(KEY_COUNT)
	) u_key_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (key_req),
		.key_bit(key_bit),
		.ready  (map_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_fire) begin
			action_s1       <= evt.action;
			key_code_s1     <= evt.key_code;
			button_s1       <= evt.button;
			wheel_delta_s1  <= evt.wheel_delta;
			pointer_x_in_s1 <= evt.pointer_x_in;
			pointer_y_in_s1 <= evt.pointer_y_in;
		end
	end

	assign key_ok_s1 = 32'(key_code_s1) < 32'(KEY_COUNT);
	assign btn_ok_s1 = button_s1 <= BTN_LAST;

	// state update for the transaction in the input register
	always_comb begin
		pressed_nxt      = pressed_q;
		count_nxt        = count_q;
		since_nxt        = since_q;
		wheel_nxt        = wheel_q;
		pointer_x_nxt    = pointer_x_q;
		pointer_y_nxt    = pointer_y_q;
		first_key_nxt    = first_key_q;
		first_button_nxt = first_button_q;
		single_nxt       = '0;
		double_nxt       = '0;
		key_state_nxt    = 1'b0;

		case (action_s1)
			ACT_KEY_DOWN: begin
				if (key_ok_s1 && first_key_q == KEY_NONE) begin
					first_key_nxt = key_code_s1;
				end
			end
			ACT_KEY_UP: begin
				if (key_ok_s1 && first_key_q == key_code_s1) begin
					first_key_nxt = KEY_NONE;
				end
			end
			ACT_BTN_DOWN: begin
				if (btn_ok_s1) begin
					for (int i = 0; i < BUTTON_SLOTS; i++) begin
						if (button_s1 == 3'(i)) begin
							pressed_nxt[i] = 1'b1;
							// restart after a timeout or past a triple click
							if (32'(since_q[i]) > 32'(timeout_q) || count_q[i] == COUNT_LIMIT) begin
								count_nxt[i] = COUNT_FIRST;
							end else begin
								count_nxt[i] = count_q[i] + 1'b1;
							end
							since_nxt[i] = '0;
						end
					end
					if (first_button_q == BTN_NONE) begin
						first_button_nxt = button_s1;
					end
				end
			end
			ACT_BTN_UP: begin
				if (btn_ok_s1) begin
					for (int i = 0; i < BUTTON_SLOTS; i++) begin
						if (button_s1 == 3'(i)) begin
							pressed_nxt[i] = 1'b0;
						end
					end
					if (button_s1 != BTN_NONE && first_button_q == button_s1) begin
						first_button_nxt = BTN_NONE;
					end
				end
			end
			ACT_WHEEL: begin
				wheel_nxt = wheel_delta_s1;
			end
			ACT_MOVE: begin
				pointer_x_nxt = pointer_x_in_s1;
				pointer_y_nxt = pointer_y_in_s1;
			end
			ACT_FRAME: begin
				wheel_nxt = '0;
			end
			ACT_TICK: begin
				// saturating elapsed timers
				for (int i = 0; i < BUTTON_SLOTS; i++) begin
					if (since_q[i] != '1) begin
						since_nxt[i] = since_q[i] + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// button none shows in no flag
		for (int i = 1; i < BUTTON_SLOTS; i++) begin
			single_nxt[i-1] = pressed_nxt[i] && count_nxt[i] == COUNT_FIRST;
			double_nxt[i-1] = pressed_nxt[i] && count_nxt[i] == COUNT_SECOND;
		end

		// own key write wins over the map read taken at the same edge
		if (!key_ok_s1) begin
			key_state_nxt = 1'b0;
		end else if (action_s1 == ACT_KEY_DOWN) begin
			key_state_nxt = 1'b1;
		end else if (action_s1 == ACT_KEY_UP) begin
			key_state_nxt = 1'b0;
		end else begin
			key_state_nxt = key_bit;
		end
	end

	// tracker state commits as the transaction moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUTTON_SLOTS; i++) begin
				pressed_q[i] <= 1'b0;
				count_q[i]   <= '0;
				since_q[i]   <= '0;
			end
			wheel_q        <= '0;
			pointer_x_q    <= '0;
			pointer_y_q    <= '0;
			first_key_q    <= KEY_NONE;
			first_button_q <= BTN_NONE;
		end else if (s1_adv) begin
			pressed_q      <= pressed_nxt;
			count_q        <= count_nxt;
			since_q        <= since_nxt;
			wheel_q        <= wheel_nxt;
			pointer_x_q    <= pointer_x_nxt;
			pointer_y_q    <= pointer_y_nxt;
			first_key_q    <= first_key_nxt;
			first_button_q <= first_button_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			key_state_q        <= key_state_nxt;
			single_q           <= single_nxt;
			double_q           <= double_nxt;
			wheel_plus_q       <= !wheel_nxt[15] && wheel_nxt != '0;
			wheel_minus_q      <= wheel_nxt[15];
			res_pointer_x_q    <= pointer_x_nxt;
			res_pointer_y_q    <= pointer_y_nxt;
			res_first_key_q    <= first_key_nxt;
			res_first_button_q <= first_button_nxt;
		end
	end

	assign res.valid              = res_valid_q;
	assign res.key_state          = key_state_q;
	assign res.single_click_flags = single_q;
	assign res.double_click_flags = double_q;
	assign res.wheel_plus         = wheel_plus_q;
	assign res.wheel_minus        = wheel_minus_q;
	assign res.pointer_x          = res_pointer_x_q;
	assign res.pointer_y          = res_pointer_y_q;
	assign res.first_key          = res_first_key_q;
	assign res.first_button       = res_first_button_q;

	// a held button always has a running click count
	always_comb begin
		held_zero_count = 1'b0;
		for (int i = 0; i < BUTTON_SLOTS; i++) begin
			if (pressed_q[i] && count_q[i] == '0) begin
				held_zero_count = 1'b1;
			end
		end
	end

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!map_ready |-> !evt.ready)
		else $error("event taken during key map clear");

	a_adv_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> res_valid_q)
		else $error("result register not loaded after advance");

	a_held_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		!held_zero_count)
		else $error("held button with zero click count");

	a_first_button_range: assert property (@(posedge clk) disable iff (!arst_n)
		first_button_q <= BTN_LAST)
		else $error("first button latch out of range");

	a_state_frozen_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(first_key_q) && $stable(wheel_q))
		else $error("tracker state moved without an advance");

endmodule
